FILE: rtl/ets_pkg.sv
// Shared constants, token record types and helper functions for the
// expression token scanner. No dependencies.
package ets_pkg;

  // Internal counter widths
  localparam int POSITION_BITS = 16;
  localparam int OFFSET_BITS   = 32;
  localparam int LENGTH_BITS   = 16;

  // Record queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int MAX_RECS    = 3;

  // Scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // Token kinds
  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_PLUS    = 3'd2;
  localparam logic [2:0] KIND_STAR    = 3'd3;
  localparam logic [2:0] KIND_LPAREN  = 3'd4;
  localparam logic [2:0] KIND_RPAREN  = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;
  localparam logic [2:0] KIND_EOF     = 3'd7;

  // Characters
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [31:0] start_offset;
    logic [15:0] length;
    logic [7:0]  single_char;
    logic        zero_appended;
    logic        last_of_run;
  } tok_rec_t;

  // All records caused by one input transfer
  typedef struct packed {
    logic [1:0]                 count;
    tok_rec_t [MAX_RECS-1:0]    recs;
  } tok_bundle_t;

  typedef struct packed {
    logic        valid;
    tok_bundle_t bundle;
  } q_push_t;

  typedef struct packed {
    logic        valid;
    tok_bundle_t bundle;
  } q_head_t;

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [POSITION_BITS-1:0] inc_pos(input logic [POSITION_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return (w > 48'h0000_0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [31:0] clamp_off(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

FILE: rtl/ets_in_if.sv
// Source byte channel: valid/ready handshake with byte, byte-present flag
// and end-of-source mark. No dependencies.
interface ets_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       ch_valid;
  logic       end_of_source;

  modport source(output valid, ch, ch_valid, end_of_source, input ready);
  modport sink(input valid, ch, ch_valid, end_of_source, output ready);
endinterface

FILE: rtl/ets_out_if.sv
// Token record channel: valid/ready handshake with one token record per
// transfer. No dependencies.
interface ets_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] line;
  logic [15:0] column;
  logic [31:0] start_offset;
  logic [15:0] length;
  logic [7:0]  single_char;
  logic        zero_appended;
  logic        last_of_run;

  modport source(output valid, kind, line, column, start_offset, length, single_char,
                 zero_appended, last_of_run, input ready);
  modport sink(input valid, kind, line, column, start_offset, length, single_char,
               zero_appended, last_of_run, output ready);
endinterface

FILE: rtl/ets_front.sv
// Scanner front: accepts source bytes, tracks position and token state,
// and builds the bundle of records each byte causes. Uses ets_pkg, ets_in_if.
module ets_front import ets_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ets_in_if.sink     src,
  output q_push_t    push,
  input  logic       q_full
);

  logic [1:0]               mode, mode_next;
  logic                     point_seen, point_seen_next;
  logic                     last_was_point, last_was_point_next;
  logic [POSITION_BITS-1:0] line, line_next;
  logic [POSITION_BITS-1:0] col, col_next;
  logic [OFFSET_BITS-1:0]   off, off_next;
  logic [POSITION_BITS-1:0] tok_col, tok_col_next;
  logic [OFFSET_BITS-1:0]   tok_off, tok_off_next;
  logic [LENGTH_BITS-1:0]   tok_len, tok_len_next;

  logic accept;

  function automatic tok_rec_t mk_rec(input logic [2:0] kind,
                                      input logic [POSITION_BITS-1:0] ln,
                                      input logic [POSITION_BITS-1:0] cl,
                                      input logic [OFFSET_BITS-1:0] of,
                                      input logic [LENGTH_BITS-1:0] ln_tok,
                                      input logic [7:0] sc,
                                      input logic za);
    tok_rec_t r;
    r.kind          = kind;
    r.line          = clamp_pos(ln);
    r.column        = clamp_pos(cl);
    r.start_offset  = clamp_off(of);
    r.length        = 16'(ln_tok);
    r.single_char   = sc;
    r.zero_appended = za;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign src.ready = !q_full;
  assign accept    = src.valid && src.ready;

  always_comb begin
    logic                     alnum, extend, in_ident, in_number;
    logic [1:0]               m_mode;
    logic                     m_ps, m_lwp;
    logic [POSITION_BITS-1:0] m_line, m_col, m_tcol;
    logic [OFFSET_BITS-1:0]   m_off, m_toff;
    logic [LENGTH_BITS-1:0]   m_tlen;
    logic [2:0]               pkind;
    tok_rec_t [3:0]           cand;
    logic [3:0]               en;
    tok_rec_t [3:0]           slot;
    logic [2:0]               n;

    alnum     = is_letter(src.ch) || is_digit(src.ch);
    in_ident  = (mode == MODE_IDENT);
    in_number = (mode == MODE_NUMBER);
    extend    = src.ch_valid &&
                ((in_ident && alnum) ||
                 (in_number && (is_digit(src.ch) || (src.ch == CH_POINT && !point_seen))));

    m_mode = mode;  m_ps = point_seen;  m_lwp = last_was_point;
    m_line = line;  m_col = col;        m_off = off;
    m_tcol = tok_col; m_toff = tok_off; m_tlen = tok_len;

    unique case (src.ch)
      CH_PLUS:   pkind = KIND_PLUS;
      CH_STAR:   pkind = KIND_STAR;
      CH_LPAREN: pkind = KIND_LPAREN;
      CH_RPAREN: pkind = KIND_RPAREN;
      default:   pkind = KIND_UNKNOWN;
    endcase

    // candidate 0: pending token closed by this byte
    cand[0] = mk_rec(in_ident ? KIND_IDENT : KIND_NUMBER, line, tok_col, tok_off, tok_len,
                     8'h00, in_number && last_was_point);
    en[0]   = src.ch_valid && !extend && (in_ident || in_number);
    // candidate 1: one-character token
    cand[1] = mk_rec(pkind, line, col, off, LENGTH_BITS'(1), src.ch, 1'b0);
    en[1]   = 1'b0;

    if (src.ch_valid) begin
      if (extend) begin
        m_tlen = inc_len(tok_len);
        m_col  = inc_pos(col);
        m_off  = inc_off(off);
        if (in_number) begin
          if (src.ch == CH_POINT) begin
            m_ps  = 1'b1;
            m_lwp = 1'b1;
          end else begin
            m_lwp = 1'b0;
          end
        end
      end else begin
        m_mode = MODE_IDLE;
        m_ps   = 1'b0;
        m_lwp  = 1'b0;
        m_tlen = '0;
        if (src.ch == CH_SPACE) begin
          m_col = inc_pos(col);
          m_off = inc_off(off);
        end else if (src.ch == CH_NEWLINE) begin
          m_line = inc_pos(line);
          m_col  = POSITION_BITS'(1);
          m_off  = inc_off(off);
        end else if (alnum) begin
          m_mode = is_letter(src.ch) ? MODE_IDENT : MODE_NUMBER;
          m_tcol = col;
          m_toff = off;
          m_tlen = LENGTH_BITS'(1);
          m_col  = inc_pos(col);
          m_off  = inc_off(off);
        end else begin
          en[1] = 1'b1;
          m_col = inc_pos(col);
          m_off = inc_off(off);
        end
      end
    end

    // candidates 2, 3: end of source closes pending token, then eof
    cand[2] = mk_rec((m_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER, m_line, m_tcol,
                     m_toff, m_tlen, 8'h00, (m_mode == MODE_NUMBER) && m_lwp);
    en[2]   = src.end_of_source && ((m_mode == MODE_IDENT) || (m_mode == MODE_NUMBER));
    cand[3] = mk_rec(KIND_EOF, m_line, m_col, m_off, '0, 8'h00, 1'b0);
    en[3]   = src.end_of_source;

    // compact enabled candidates into slots
    slot = '0;
    n    = '0;
    for (int i = 0; i < 4; i++) begin
      if (en[i]) begin
        slot[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    for (int i = 0; i < MAX_RECS; i++) begin
      slot[i].last_of_run = (3'(i) == n - 3'd1);
    end

    push.valid         = accept && (n != 3'd0);
    push.bundle.count  = n[1:0];
    push.bundle.recs   = slot[MAX_RECS-1:0];

    if (src.end_of_source) begin
      mode_next           = MODE_IDLE;
      point_seen_next     = 1'b0;
      last_was_point_next = 1'b0;
      line_next           = POSITION_BITS'(1);
      col_next            = POSITION_BITS'(1);
      off_next            = '0;
      tok_col_next        = '0;
      tok_off_next        = '0;
      tok_len_next        = '0;
    end else begin
      mode_next           = m_mode;
      point_seen_next     = m_ps;
      last_was_point_next = m_lwp;
      line_next           = m_line;
      col_next            = m_col;
      off_next            = m_off;
      tok_col_next        = m_tcol;
      tok_off_next        = m_toff;
      tok_len_next        = m_tlen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      point_seen     <= 1'b0;
      last_was_point <= 1'b0;
      line           <= POSITION_BITS'(1);
      col            <= POSITION_BITS'(1);
      off            <= '0;
      tok_col        <= '0;
      tok_off        <= '0;
      tok_len        <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      point_seen     <= point_seen_next;
      last_was_point <= last_was_point_next;
      line           <= line_next;
      col            <= col_next;
      off            <= off_next;
      tok_col        <= tok_col_next;
      tok_off        <= tok_off_next;
      tok_len        <= tok_len_next;
    end
  end

endmodule

FILE: rtl/ets_queue.sv
// Bundle queue between scanner front and record back end.
// Uses ets_pkg.
module ets_queue import ets_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_push_t push,
  output logic    full,
  output q_head_t head,
  input  logic    pop
);

  tok_bundle_t          mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push, do_pop;

  assign full        = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign do_push     = push.valid && !full;
  assign do_pop      = pop && (count != '0);
  assign head.valid  = (count != '0);
  assign head.bundle = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end
  end

endmodule

FILE: rtl/ets_back.sv
// Record back end: takes one bundle at a time from the queue and sends its
// records out one per transfer. Uses ets_pkg, ets_out_if.
module ets_back import ets_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    head,
  output logic       pop,
  ets_out_if.source  tok
);

  logic        busy;
  tok_bundle_t cur;
  logic [1:0]  idx;
  logic        xfer, done, load;
  tok_rec_t    rec;

  assign xfer = tok.valid && tok.ready;
  assign done = xfer && (idx == cur.count - 2'd1);
  assign load = head.valid && (!busy || done);
  assign pop  = load;

  always_comb begin
    case (idx)
      2'd1:    rec = cur.recs[1];
      2'd2:    rec = cur.recs[2];
      default: rec = cur.recs[0];
    endcase
  end

  assign tok.valid         = busy;
  assign tok.kind          = rec.kind;
  assign tok.line          = rec.line;
  assign tok.column        = rec.column;
  assign tok.start_offset  = rec.start_offset;
  assign tok.length        = rec.length;
  assign tok.single_char   = rec.single_char;
  assign tok.zero_appended = rec.zero_appended;
  assign tok.last_of_run   = rec.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (xfer) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head.bundle;
    end
  end

endmodule

FILE: rtl/expression_token_scanner.sv
// Expression token scanner: takes one source byte per transfer on src and
// sends token records on tok. A byte may cause zero to three records (a
// pending identifier or number it closes, a one-character token, and on
// end of source the final eof record); the records of one byte leave in
// order, the last one flagged last_of_run. The front takes a new byte every
// cycle while the four-entry bundle queue has room, so a burst of bytes is
// scanned at one byte per cycle; the back end sends one record per cycle
// while tok is ready, so the sustained rate is one byte per cycle whenever
// bytes average at most one record each and tok stays ready. A record is
// written into the queue at the byte transfer, then registered into the
// back end once that is idle or sends its last record, and is then valid
// on tok. Line, column and offsets saturate; after end of source all
// state returns to its reset values and a new source text begins. Depends
// on ets_pkg, ets_in_if, ets_out_if, ets_front, ets_queue and ets_back.
module expression_token_scanner import ets_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ets_in_if.sink    src,
  ets_out_if.source tok
);

  q_push_t push;
  logic    q_full;
  q_head_t head;
  logic    pop;

  // classify bytes, keep position and token state
  ets_front u_front (
    .clk    (clk),
    .rst    (rst),
    .src    (src),
    .push   (push),
    .q_full (q_full)
  );

  // decouples scanning from record output stalls
  ets_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // one record per transfer
  ets_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .tok  (tok)
  );

endmodule

FILE: bench/expression_token_scanner_checker.sv
// Token record checker: watches the byte and token channels, predicts the
// token records of every byte transfer and compares them in order.
// Depends on ets_pkg, ets_in_if and ets_out_if.
module expression_token_scanner_checker import ets_pkg::*; (
  input  logic clk,
  input  logic rst,
  ets_in_if    src,
  ets_out_if   tok,
  output int   errors,
  output int   outstanding
);

  localparam int PRINT_LIMIT = 100;

  // scanner state as predicted
  logic [1:0]  mode;
  logic        pt_seen;
  logic        trail_pt;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [31:0] offs;
  logic [15:0] tok_col;
  logic [31:0] tok_off;
  logic [15:0] tok_len;

  tok_rec_t run_q[$];   // records of the transfer being scanned
  tok_rec_t want_q[$];  // records still owed by the block
  int err_count = 0;

  assign errors = err_count;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] sat32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] c);
    case (c)
      CH_PLUS:   return KIND_PLUS;
      CH_STAR:   return KIND_STAR;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      default:   return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic void restart();
    mode     = MODE_IDLE;
    pt_seen  = 1'b0;
    trail_pt = 1'b0;
    line_no  = 16'd1;
    col_no   = 16'd1;
    offs     = '0;
    tok_col  = '0;
    tok_off  = '0;
    tok_len  = '0;
  endfunction

  function automatic void step_col();
    col_no = sat16(col_no);
    offs   = sat32(offs);
  endfunction

  function automatic void add_rec(input logic [2:0] kind, input logic [15:0] col,
                                  input logic [31:0] off, input logic [15:0] len,
                                  input logic [7:0] sc, input logic za);
    tok_rec_t r;
    r               = '0;
    r.kind          = kind;
    r.line          = line_no;
    r.column        = col;
    r.start_offset  = off;
    r.length        = len;
    r.single_char   = sc;
    r.zero_appended = za;
    run_q.push_back(r);
  endfunction

  // emit the identifier or number in progress, if any
  function automatic void close_token();
    if (mode == MODE_IDENT)
      add_rec(KIND_IDENT, tok_col, tok_off, tok_len, 8'h00, 1'b0);
    else if (mode == MODE_NUMBER)
      add_rec(KIND_NUMBER, tok_col, tok_off, tok_len, 8'h00, trail_pt);
    mode     = MODE_IDLE;
    pt_seen  = 1'b0;
    trail_pt = 1'b0;
    tok_len  = '0;
  endfunction

  function automatic void scan_transfer(input logic [7:0] c, input logic cv, input logic e);
    logic     grow;
    tok_rec_t r;
    grow = 1'b0;
    run_q.delete();
    if (cv) begin
      if (mode == MODE_IDENT && (is_alpha(c) || is_num(c))) begin
        grow = 1'b1;
      end else if (mode == MODE_NUMBER && (is_num(c) || (c == CH_POINT && !pt_seen))) begin
        grow     = 1'b1;
        trail_pt = (c == CH_POINT);
        if (c == CH_POINT) pt_seen = 1'b1;
      end
      if (grow) begin
        tok_len = sat16(tok_len);
        step_col();
      end else begin
        // byte can't extend the token: close it, then scan the byte fresh
        close_token();
        if (c == CH_SPACE) begin
          step_col();
        end else if (c == CH_NEWLINE) begin
          line_no = sat16(line_no);
          col_no  = 16'd1;
          offs    = sat32(offs);
        end else if (is_alpha(c) || is_num(c)) begin
          mode     = is_alpha(c) ? MODE_IDENT : MODE_NUMBER;
          pt_seen  = 1'b0;
          trail_pt = 1'b0;
          tok_col  = col_no;
          tok_off  = offs;
          tok_len  = 16'd1;
          step_col();
        end else begin
          add_rec(kind_of(c), col_no, offs, 16'd1, c, 1'b0);
          step_col();
        end
      end
    end
    if (e) begin
      close_token();
      add_rec(KIND_EOF, col_no, offs, 16'd0, 8'h00, 1'b0);
      restart();
    end
    if (run_q.size() != 0) begin
      r = run_q.pop_back();
      r.last_of_run = 1'b1;
      run_q.push_back(r);
    end
    foreach (run_q[i]) want_q.push_back(run_q[i]);
  endfunction

  task automatic report(input string msg);
    if (err_count < PRINT_LIMIT) $display("%0t token check: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    tok_rec_t want;
    if (rst) begin
      restart();
      want_q.delete();
      outstanding <= 0;
    end else begin
      // compare first so a record can't be matched against its own byte
      if (tok.valid && tok.ready) begin
        if (want_q.size() == 0) begin
          report("token record with none expected");
        end else begin
          want = want_q.pop_front();
          check_field("kind", 32'(tok.kind), 32'(want.kind));
          check_field("line", 32'(tok.line), 32'(want.line));
          check_field("column", 32'(tok.column), 32'(want.column));
          check_field("start_offset", tok.start_offset, want.start_offset);
          check_field("length", 32'(tok.length), 32'(want.length));
          check_field("single_char", 32'(tok.single_char), 32'(want.single_char));
          check_field("zero_appended", 32'(tok.zero_appended), 32'(want.zero_appended));
          check_field("last_of_run", 32'(tok.last_of_run), 32'(want.last_of_run));
        end
      end
      if (src.valid && src.ready)
        scan_transfer(src.ch, src.ch_valid, src.end_of_source);
      outstanding <= want_q.size();
    end
  end

endmodule

FILE: bench/expression_token_scanner_test.sv
// Testbench top for the expression token scanner: clock, reset, byte
// stimulus, random back-pressure on the token channel and the verdict.
// Depends on ets_pkg, ets_in_if, ets_out_if, the scanner and the token record checker.
module expression_token_scanner_test;
  import ets_pkg::*;

  localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer on either side
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_CYCLES  = 10;

  logic clk;
  logic rst;
  logic steady;        // high: neither side inserts idle cycles
  int   errors;
  int   outstanding;
  int   quiet = 0;
  int   sent  = 0;     // byte or end-mark transfers; ignored items don't count

  ets_in_if  src ();
  ets_out_if tok ();

  expression_token_scanner DUT (
    .clk (clk),
    .rst (rst),
    .src (src),
    .tok (tok)
  );

  expression_token_scanner_checker token_check (
    .clk         (clk),
    .rst         (rst),
    .src         (src),
    .tok         (tok),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Token side back-pressure: ready drops at random, with a chance of about 7 in 100.
  initial begin
    tok.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tok.ready <= !rst && (steady || ($urandom_range(99) >= 7));
    end
  end

  // Watchdog: a hung handshake or a missing record shows up as a long
  // stretch with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (src.valid && src.ready) || (tok.valid && tok.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("expression_token_scanner_test: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] letter_byte();
    return ($urandom_range(1) != 0) ? 8'("a" + $urandom_range(25))
                                    : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'("0" + $urandom_range(9));
  endfunction

  // One transfer on the byte channel. Called right after an edge; valid is
  // either kept high for the next item or dropped for an idle gap, never
  // both in the same step.
  task automatic put_byte(input logic [7:0] c, input logic cv, input logic e);
    while (!steady && ($urandom_range(99) < 7)) begin
      src.valid <= 1'b0;
      @(posedge clk);
    end
    src.valid         <= 1'b1;
    src.ch            <= c;
    src.ch_valid      <= cv;
    src.end_of_source <= e;
    do @(posedge clk); while (!src.ready);
    if (cv || e) sent++;
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put_byte(s[i], 1'b1, 1'b0);
  endtask

  // Mostly well-formed expression pieces with random content, with some
  // junk bytes, empty items and source ends mixed in.
  task automatic random_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 22) begin
      // identifier; digits may follow the first letter
      n = $urandom_range(1, 6);
      put_byte(letter_byte(), 1'b1, 1'b0);
      repeat (n - 1)
        put_byte(($urandom_range(2) == 0) ? digit_byte() : letter_byte(), 1'b1, 1'b0);
    end else if (pick < 44) begin
      n = $urandom_range(1, 4);
      repeat (n) put_byte(digit_byte(), 1'b1, 1'b0);
      case ($urandom_range(3))
        0: ;
        1: begin
          put_byte(CH_POINT, 1'b1, 1'b0);
          repeat ($urandom_range(3)) put_byte(digit_byte(), 1'b1, 1'b0);
        end
        2: put_byte(CH_POINT, 1'b1, 1'b0);       // trailing point
        default: begin                          // second point splits it
          put_byte(CH_POINT, 1'b1, 1'b0);
          put_byte(digit_byte(), 1'b1, 1'b0);
          put_byte(CH_POINT, 1'b1, 1'b0);
        end
      endcase
    end else if (pick < 64) begin
      case ($urandom_range(3))
        0: put_byte(CH_PLUS, 1'b1, 1'b0);
        1: put_byte(CH_STAR, 1'b1, 1'b0);
        2: put_byte(CH_LPAREN, 1'b1, 1'b0);
        default: put_byte(CH_RPAREN, 1'b1, 1'b0);
      endcase
    end else if (pick < 78) begin
      put_byte(CH_SPACE, 1'b1, 1'b0);
    end else if (pick < 84) begin
      put_byte(CH_NEWLINE, 1'b1, 1'b0);
    end else if (pick < 92) begin
      put_byte(8'($urandom_range(255)), 1'b1, 1'b0);
    end else if (pick < 95) begin
      // empty item: must produce nothing
      put_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end else begin
      // end of source, with or without a last byte
      put_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end
  endtask

  initial begin
    rst               <= 1'b1;
    steady            <= 1'b0;
    src.valid         <= 1'b0;
    src.ch            <= 8'h00;
    src.ch_valid      <= 1'b0;
    src.end_of_source <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: identifier with upper case and digit, trailing point,
    // second point, every operator, newline, tab as unknown.
    put_text("Az9 1.+2.5.*(x)\n\t");
    put_byte(8'hFF, 1'b1, 1'b0);             // high byte: unknown
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'h5A, 1'b0, 1'b0);             // no byte, no end
    // end on an operator closing an identifier: three records in one run
    put_byte("q", 1'b1, 1'b0);
    put_byte(CH_PLUS, 1'b1, 1'b1);
    // bare end mark closing a number that ends with its point
    put_byte("5", 1'b1, 1'b0);
    put_byte(CH_POINT, 1'b1, 1'b0);
    put_byte(8'hA5, 1'b0, 1'b1);

    // Random part, with a stretch of full rate on both sides
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady <= (sent >= 150) && (sent < 250);
      random_token();
    end
    steady <= 1'b0;

    src.valid <= 1'b0;
    // let the checker see the last transfer before reading its count
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("expression_token_scanner_test: done, clean");
    else
      $display("expression_token_scanner_test: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ets_pkg.sv
rtl/ets_in_if.sv
rtl/ets_out_if.sv
rtl/ets_front.sv
rtl/ets_queue.sv
rtl/ets_back.sv
rtl/expression_token_scanner.sv
bench/expression_token_scanner_checker.sv
bench/expression_token_scanner_test.sv
